// File: rtl/adaptive_range_encoder_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the adaptive range encoder
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ADAPTIVE_RANGE_ENCODER_UNIT_MACROS_SVH
`define ADAPTIVE_RANGE_ENCODER_UNIT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ARE_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the next cycle
`define ARE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/are_pkg.sv
// ----------------------------------------------------------------------------
// Adaptive range encoder package
// Types and fixed constants shared by the encoder modules.
// ----------------------------------------------------------------------------
package are_pkg;

	localparam int SYM_W = 8;
	localparam int CNT_W = 17;

	typedef logic [CNT_W-1:0] count_t;

	localparam count_t      RESCALE_LIMIT = 17'h0FFFF;
	localparam logic [31:0] RENORM_BOUND  = 32'h0001_0000;
	localparam logic [31:0] RANGE_INIT    = 32'hFFFF_FFFF;
	localparam logic [7:0]  CLAMP_BYTE    = 8'hFF;

	// operation codes carried on tuser
	localparam logic OP_ENCODE = 1'b0;
	localparam logic OP_FLUSH  = 1'b1;

	// per-cell control
	typedef struct packed {
		logic inc;   // add one to this count
		logic tok;   // rescale token arriving from the left neighbor
	} cell_ctl_t;

	typedef enum logic [7:0] {
		ST_IDLE   = 8'b0000_0001,
		ST_DIV    = 8'b0000_0010,
		ST_MUL    = 8'b0000_0100,
		ST_ADD    = 8'b0000_1000,
		ST_CHK    = 8'b0001_0000,
		ST_RESC   = 8'b0010_0000,
		ST_RENORM = 8'b0100_0000,
		ST_FLUSH  = 8'b1000_0000
	} state_t;

endpackage

// File: rtl/adaptive_range_encoder_unit.sv
// ----------------------------------------------------------------------------
// Adaptive range encoder unit
// Order-0 adaptive byte range encoder, 32-bit low and range, with the
// cumulative count table held in a row of count cells.
//
//   channel   dir  tdata             tuser          tlast
//   s_axis    in   symbol [7:0]      operation [0]  -
//   m_axis    out  out_byte [7:0]    -              last
//
// Encode: accept, then serial divide, multiply, add and check states, then
// the renormalize state emits up to 8 bytes, or none.
// A rescale waits in its state while the token walks the cell row.
// Flush: 4 byte beats. Outputs stall freely on m_axis_tready.
// Reset restores the count table, low = 0 and range = all ones at once.
// ----------------------------------------------------------------------------
module adaptive_range_encoder_unit #(
	parameter int ALPHABET = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] symbol
	input  logic        s_axis_tuser,   // [0] operation
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
	output logic        m_axis_tlast
);

`include "adaptive_range_encoder_unit_macros.svh"

	localparam int NCELL = ALPHABET + 1;
	localparam int NGRP  = (NCELL + 15) / 16;

	are_pkg::state_t    state_q;
	logic [31:0]        low_q;
	logic [31:0]        range_q;
	logic [7:0]         sym_q;
	logic [2:0]         n_q;
	logic [1:0]         fcnt_q;
	logic               out_valid_q;
	logic [7:0]         out_byte_q;
	logic               out_last_q;

	are_pkg::count_t    cell_val [NCELL];
	logic               cell_tok [NCELL];
	are_pkg::cell_ctl_t cell_ctl [NCELL];

	are_pkg::count_t    grp_a_s1 [NGRP];
	are_pkg::count_t    grp_b_s1 [NGRP];
	are_pkg::count_t    grp_a_c  [NGRP];
	are_pkg::count_t    grp_b_c  [NGRP];
	are_pkg::count_t    cum_lo_c;
	are_pkg::count_t    cum_hi_c;
	are_pkg::count_t    cum_lo_q;
	are_pkg::count_t    cum_hi_q;

	logic [31:0]        prod_lo_q;
	logic [31:0]        prod_r_q;

	logic               accept;
	logic               enc_ok;
	logic               div_start;
	logic               div_done;
	logic [31:0]        div_quot;
	are_pkg::count_t    total;
	logic [8:0]         sym_hi;
	logic               slot_free;
	logic               over;

	// renormalization step
	logic [16:0]        clamp_sum;
	logic               clamp;
	logic [31:0]        rng_c;
	logic [31:0]        rng_next;
	logic               more;
	logic               emit;

	assign s_axis_tready = (state_q == are_pkg::ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign enc_ok        = ({1'b0, s_axis_tdata} < 9'(ALPHABET));
	assign div_start     = accept && (s_axis_tuser == are_pkg::OP_ENCODE) && enc_ok;
	assign total         = (cell_val[ALPHABET] == '0) ? are_pkg::count_t'(1)
	                                                  : cell_val[ALPHABET];
	assign sym_hi        = {1'b0, sym_q} + 9'd1;
	assign slot_free     = !out_valid_q || m_axis_tready;
	assign over          = cell_val[ALPHABET] > are_pkg::RESCALE_LIMIT;

	are_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (range_q),
		.divisor  (total),
		.done     (div_done),
		.quotient (div_quot)
	);

	// row of count cells, token chained left to right
	for (genvar j = 0; j < NCELL; j++) begin : g_cell
		assign cell_ctl[j].inc = (state_q == are_pkg::ST_ADD) && (9'(j) > {1'b0, sym_q});
		if (j == 0) begin : g_first
			assign cell_ctl[j].tok = (state_q == are_pkg::ST_CHK) && over;
			are_cell #(.INDEX(j)) u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.ctl      (cell_ctl[j]),
				.left_val ('1),
				.val      (cell_val[j]),
				.tok_out  (cell_tok[j])
			);
		end else begin : g_rest
			assign cell_ctl[j].tok = cell_tok[j-1];
			are_cell #(.INDEX(j)) u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.ctl      (cell_ctl[j]),
				.left_val (cell_val[j-1]),
				.val      (cell_val[j]),
				.tok_out  (cell_tok[j])
			);
		end
	end

	// two-stage select of cum[s] and cum[s+1], groups of 16
	for (genvar g = 0; g < NGRP; g++) begin : g_grp
		always_comb begin
			grp_a_c[g] = '0;
			grp_b_c[g] = '0;
			for (int k = 0; k < 16; k++) begin
				if (g * 16 + k < NCELL) begin
					if (9'(g * 16 + k) == {1'b0, sym_q})
						grp_a_c[g] = grp_a_c[g] | cell_val[g * 16 + k];
					if (9'(g * 16 + k) == sym_hi)
						grp_b_c[g] = grp_b_c[g] | cell_val[g * 16 + k];
				end
			end
		end
		always_ff @(posedge clk) begin
			grp_a_s1[g] <= grp_a_c[g];
			grp_b_s1[g] <= grp_b_c[g];
		end
	end

	// merge the group picks
	always_comb begin
		cum_lo_c = '0;
		cum_hi_c = '0;
		for (int g = 0; g < NGRP; g++) begin
			cum_lo_c = cum_lo_c | grp_a_s1[g];
			cum_hi_c = cum_hi_c | grp_b_s1[g];
		end
	end

	always_ff @(posedge clk) begin
		cum_lo_q <= cum_lo_c;
		cum_hi_q <= cum_hi_c;
	end

	// clamp and shift for one renormalization byte
	assign clamp_sum = {1'b0, range_q[15:0]} + {1'b0, low_q[15:0]};
	assign clamp     = (low_q[23:16] == are_pkg::CLAMP_BYTE) && clamp_sum[16];
	assign rng_c     = clamp ? 32'(17'h10000 - {1'b0, low_q[15:0]}) : range_q;
	assign rng_next  = rng_c << 8;
	assign more      = (rng_next < are_pkg::RENORM_BOUND) && (n_q != 3'd7);
	assign emit      = slot_free && (((state_q == are_pkg::ST_RENORM)
	                   && (range_q < are_pkg::RENORM_BOUND)) || (state_q == are_pkg::ST_FLUSH));

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= are_pkg::ST_IDLE;
			low_q   <= '0;
			range_q <= are_pkg::RANGE_INIT;
			n_q     <= '0;
			fcnt_q  <= '0;
		end else begin
			case (state_q)
				are_pkg::ST_IDLE: begin
					if (accept && s_axis_tuser == are_pkg::OP_FLUSH) begin
						fcnt_q  <= '0;
						state_q <= are_pkg::ST_FLUSH;
					end else if (div_start) begin
						state_q <= are_pkg::ST_DIV;
					end
				end
				are_pkg::ST_DIV: begin
					if (div_done) state_q <= are_pkg::ST_MUL;
				end
				are_pkg::ST_MUL: begin
					state_q <= are_pkg::ST_ADD;
				end
				are_pkg::ST_ADD: begin
					low_q   <= low_q + prod_lo_q;
					range_q <= prod_r_q;
					state_q <= are_pkg::ST_CHK;
				end
				are_pkg::ST_CHK: begin
					n_q     <= '0;
					state_q <= over ? are_pkg::ST_RESC : are_pkg::ST_RENORM;
				end
				are_pkg::ST_RESC: begin
					if (cell_tok[ALPHABET]) state_q <= are_pkg::ST_RENORM;
				end
				are_pkg::ST_RENORM: begin
					if (range_q >= are_pkg::RENORM_BOUND) begin
						state_q <= are_pkg::ST_IDLE;
					end else if (emit) begin
						low_q   <= low_q << 8;
						range_q <= rng_next;
						n_q     <= n_q + 1'b1;
						if (!more) state_q <= are_pkg::ST_IDLE;
					end
				end
				are_pkg::ST_FLUSH: begin
					if (emit) begin
						low_q  <= low_q << 8;
						fcnt_q <= fcnt_q + 1'b1;
						if (fcnt_q == 2'd3) state_q <= are_pkg::ST_IDLE;
					end
				end
				default: state_q <= are_pkg::ST_IDLE;
			endcase
		end
	end

	// symbol latch and products
	always_ff @(posedge clk) begin
		if (accept) sym_q <= s_axis_tdata;
		if (state_q == are_pkg::ST_MUL) begin
			prod_lo_q <= 32'({15'd0, cum_lo_q} * div_quot);
			prod_r_q  <= 32'({15'd0, are_pkg::count_t'(cum_hi_q - cum_lo_q)} * div_quot);
		end
	end

	// output beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q <= low_q[31:24];
			out_last_q <= (state_q == are_pkg::ST_FLUSH) ? (fcnt_q == 2'd3) : !more;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_byte_q;
	assign m_axis_tlast  = out_last_q;

	// checks
	`ARE_ASSERT_IMPL(a_div_in_div, div_done, state_q == are_pkg::ST_DIV,
		"divider finished outside the divide phase")
	`ARE_ASSERT_IMPL(a_tok_in_resc, cell_tok[ALPHABET], state_q == are_pkg::ST_RESC,
		"rescale token left the cell row outside the rescale phase")
	`ARE_ASSERT_IMPL(a_emit_free, emit, !out_valid_q || m_axis_tready,
		"byte emitted over a pending beat")
	`ARE_ASSERT_NEXT(a_flush_go, accept && s_axis_tuser == are_pkg::OP_FLUSH,
		state_q == are_pkg::ST_FLUSH, "flush beat did not start a flush")

endmodule

// File: rtl/are_cell.sv
// ----------------------------------------------------------------------------
// Count cell
// Holds one cumulative count; increments it, and rescales it when the
// rescale token passes, using the already rescaled count of its left neighbor.
// ----------------------------------------------------------------------------
module are_cell #(
	parameter int INDEX = 0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  are_pkg::cell_ctl_t  ctl,
	input  are_pkg::count_t     left_val,
	output are_pkg::count_t     val,
	output logic                tok_out
);

	are_pkg::count_t cnt_q;
	logic            tok_q;
	are_pkg::count_t half;

	assign half = cnt_q >> 1;

	// count update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= are_pkg::count_t'(INDEX);
			tok_q <= 1'b0;
		end else begin
			tok_q <= ctl.tok;
			if (ctl.tok) begin
				// halve, keep strictly above the left neighbor
				cnt_q <= (half <= left_val) ? left_val + 1'b1 : half;
			end else if (ctl.inc) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	assign val     = cnt_q;
	assign tok_out = tok_q;

endmodule

// File: rtl/are_div.sv
// ----------------------------------------------------------------------------
// Range divider
// Restoring divider, 32-bit dividend by 17-bit divisor, one quotient bit
// per cycle.
// ----------------------------------------------------------------------------
module are_div (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [31:0]         dividend,
	input  are_pkg::count_t     divisor,
	output logic                done,
	output logic [31:0]         quotient
);

	logic [31:0]      quo_q;
	logic [17:0]      rem_q;
	are_pkg::count_t  dvs_q;
	logic [5:0]       cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [17:0]      trial;
	logic             fits;

	assign trial = {rem_q[16:0], quo_q[31]};
	assign fits  = trial >= {1'b0, dvs_q};

	// one bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == 6'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? trial - {1'b0, dvs_q} : trial;
			quo_q <= {quo_q[30:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Adaptive range encoder testbench
// Drives symbol and flush beats into the encoder, predicts every emitted code
// byte with a local model of the count table, low and range, and checks each
// output beat in order. Random idling on both sides, plus a long output hold.
// ----------------------------------------------------------------------------
module testbench;

	localparam int NSYM       = 256;
	localparam int IDLE_LIMIT = 20000;

	typedef struct packed {
		logic [7:0] code;
		logic       tail;
	} code_beat_t;

	// --------------------------------------------------------------------
	// scoreboard: encoder prediction and expected byte queue
	// --------------------------------------------------------------------
	class code_scoreboard;
		logic [16:0] cum [NSYM+1];
		logic [31:0] low;
		logic [31:0] range;
		code_beat_t  pending [$];
		int          errors;

		function void init();
			for (int j = 0; j <= NSYM; j++)
				cum[j] = 17'(j);
			low    = '0;
			range  = are_pkg::RANGE_INIT;
			errors = 0;
			pending.delete();
		endfunction

		function void emit_top();
			code_beat_t b;
			b.code = low[31:24];
			b.tail = 1'b0;
			pending.push_back(b);
			low = low << 8;
		endfunction

		function void note_input(logic op, logic [7:0] sym);
			logic [31:0] total, lo16;
			int          n;
			int          first;
			first = pending.size();
			n = 0;
			if (op == are_pkg::OP_FLUSH) begin
				for (int k = 0; k < 4; k++)
					emit_top();
				pending[pending.size()-1].tail = 1'b1;
				return;
			end
			total = 32'(cum[NSYM]);
			if (total == 0)
				total = 1;
			range = range / total;
			low   = low + 32'(cum[sym]) * range;
			range = range * 32'(cum[sym+1] - cum[sym]);
			// count update and rescale
			for (int j = sym + 1; j <= NSYM; j++)
				cum[j] = cum[j] + 1;
			if (cum[NSYM] > are_pkg::RESCALE_LIMIT) begin
				cum[0] = cum[0] >> 1;
				for (int j = 1; j <= NSYM; j++) begin
					cum[j] = cum[j] >> 1;
					if (cum[j] <= cum[j-1])
						cum[j] = cum[j-1] + 1;
				end
			end
			// renormalize with carry-avoiding clamp
			while (range < are_pkg::RENORM_BOUND && n < 8) begin
				lo16 = low & 32'hFFFF;
				if (low[23:16] == are_pkg::CLAMP_BYTE &&
					range + lo16 >= are_pkg::RENORM_BOUND)
					range = are_pkg::RENORM_BOUND - lo16;
				emit_top();
				range = range << 8;
				n++;
			end
			if (pending.size() > first)
				pending[pending.size()-1].tail = 1'b1;
		endfunction

		function void check_output(logic [7:0] code, logic tail);
			code_beat_t e;
			if (pending.size() == 0) begin
				$error("unexpected output beat: out_byte %h last %b", code, tail);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (code !== e.code) begin
				$error("out_byte: expected %h, actual %h", e.code, code);
				errors++;
			end
			if (tail !== e.tail) begin
				$error("last: expected %b, actual %b", e.tail, tail);
				errors++;
			end
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_axis_tvalid = 1'b0;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata = '0;  // [7:0] symbol
	logic       s_axis_tuser = 1'b0;  // [0] operation
	logic       m_axis_tvalid;
	logic       m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;       // [7:0] out_byte
	logic       m_axis_tlast;

	code_scoreboard sb = new();
	int  send_idle_pct = 0;
	int  recv_stall_pct = 0;
	bit  hold_output = 1'b0;
	int  idle_cycles = 0;

	always #10 clk = ~clk;

	adaptive_range_encoder_unit dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
	);

	// output side: random stall, check accepted beats
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_output(m_axis_tdata, m_axis_tlast);
		m_axis_tready <= arst_n && !hold_output &&
			($urandom_range(99) >= recv_stall_pct);
	end

	// watchdog on cycles with no accepted beat
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// one input beat, with random idle before it; valid stays up after the
	// accept until the next beat or an explicit idle replaces it
	task automatic send_beat(logic op, logic [7:0] sym);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= sym;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		sb.note_input(op, sym);
	endtask

	task automatic drain_outputs();
		s_axis_tvalid <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	// random symbol, mostly skewed toward a few values to drive adaptation
	function automatic logic [7:0] pick_symbol();
		case ($urandom_range(3))
			0: return 8'($urandom_range(255));
			1: return 8'($urandom_range(3));
			2: return 8'($urandom_range(255, 250));
			default: return 8'h41;
		endcase
	endfunction

	task automatic random_phase(int count);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(19) == 0)
				send_beat(are_pkg::OP_FLUSH, 8'($urandom_range(255)));
			else
				send_beat(are_pkg::OP_ENCODE, pick_symbol());
		end
	endtask

	initial begin
		sb.init();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, flush on fresh state, a long run of one symbol
		send_beat(are_pkg::OP_FLUSH, 8'h00);
		send_beat(are_pkg::OP_ENCODE, 8'h00);
		send_beat(are_pkg::OP_ENCODE, 8'hFF);
		send_beat(are_pkg::OP_ENCODE, 8'h80);
		send_beat(are_pkg::OP_ENCODE, 8'h7F);
		send_beat(are_pkg::OP_ENCODE, 8'h55);
		send_beat(are_pkg::OP_ENCODE, 8'hAA);
		send_beat(are_pkg::OP_FLUSH, 8'hFF);
		for (int i = 0; i < 12; i++)
			send_beat(are_pkg::OP_ENCODE, 8'hFF);
		send_beat(are_pkg::OP_ENCODE, 8'h00);
		send_beat(are_pkg::OP_FLUSH, 8'h5A);
		drain_outputs();

		// receiver holds off while the sender keeps offering
		fork
			begin
				hold_output = 1'b1;
				repeat (600) @(posedge clk);
				hold_output = 1'b0;
			end
			begin
				random_phase(30);
				s_axis_tvalid <= 1'b0;
			end
		join
		drain_outputs();

		random_phase(90);
		send_idle_pct = 57;
		random_phase(90);
		drain_outputs();
		send_idle_pct = 0;
		recv_stall_pct = 57;
		random_phase(90);
		send_idle_pct = 32;
		recv_stall_pct = 32;
		random_phase(90);
		send_beat(are_pkg::OP_FLUSH, 8'h00);

		drain_outputs();
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule

// File: files.f
+incdir+rtl
rtl/are_pkg.sv
rtl/are_cell.sv
rtl/are_div.sv
rtl/adaptive_range_encoder_unit.sv
tb/testbench.sv
